// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PSFP_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psfp assertion failed");

// consequent must hold in the cycle after the antecedent
`define PSFP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psfp assertion failed");

`endif

// File: hw/rtl/psfp_pkg.sv
// types, constants and helper functions of the point source field propagator
package psfp_pkg;

   localparam int COORD_W = 32;
   localparam int FIELD_W = 24;
   localparam int SUM_W = 48;
   localparam int DIFF_W = 33;
   localparam int SQ_W = 66;
   localparam int RAD_W = 68;
   localparam int ROOT_W = 34;
   localparam int REM_W = 38;
   localparam int SQRT_STEPS = 34;
   localparam int STEP_W = 6;
   localparam int DIV_REM_W = 35;
   localparam int QUO_W = 49;
   localparam int PLANAR_SHIFT = 24;
   localparam int SIN_TERMS = 6;

   localparam logic [STEP_W-1:0] DIV_LAST_STEP = 6'd52;
   localparam logic [STEP_W-1:0] SPATIAL_NUM_BIT = 6'd48;
   localparam logic [STEP_W-1:0] PLANAR_NUM_BIT = 6'd52;
   localparam logic [STEP_W-1:0] SQRT_DONE_STEP = 6'd34;
   localparam logic [2:0] SIN_LAST_TERM = 3'd5;

   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   localparam logic [1:0] CMD_STORE = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_EVAL = 2'd2;

   localparam logic [1:0] CSR_WAVE_TURNS = 2'd0;
   localparam logic [1:0] CSR_DIRECTION = 2'd1;
   localparam logic [1:0] CSR_GEOMETRY = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      point_type pos;
      logic signed [FIELD_W-1:0] re;
      logic signed [FIELD_W-1:0] im;
   } source_type;

   typedef struct packed {
      logic [31:0] wave_turns;
      logic direction;
      logic geometry_mode;
   } csr_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] re;
      logic signed [SUM_W-1:0] im;
      logic zero;
   } term_result_type;

   typedef struct packed {
      logic [RAD_W-1:0] rad;
      logic [REM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } sqrt_stage_type;

   typedef enum logic [2:0] {
      TOP_IDLE,
      TOP_READ,
      TOP_START,
      TOP_WAIT,
      TOP_RESULT
   } top_state_type;

   typedef enum logic [4:0] {
      TS_IDLE,
      TS_DIFF,
      TS_SQUARE,
      TS_SUM,
      TS_ROOT,
      TS_ROOT_W,
      TS_DIV,
      TS_PHASE,
      TS_SIN_X,
      TS_SIN_X2,
      TS_SIN_PROD,
      TS_SIN_EST,
      TS_SIN_FIX,
      TS_SIN_END,
      TS_QUAD,
      TS_MUL,
      TS_COMB,
      TS_MAG,
      TS_SCALE,
      TS_TERM,
      TS_DONE
   } term_state_type;

   // denominators of the sine series, innermost first
   function automatic logic [7:0] sin_den(input logic [2:0] k);
      logic [7:0] d;
      case (k)
         3'd0: d = 8'd156;
         3'd1: d = 8'd110;
         3'd2: d = 8'd72;
         3'd3: d = 8'd42;
         3'd4: d = 8'd20;
         3'd5: d = 8'd6;
         default: d = 8'd6;
      endcase
      return d;
   endfunction

   // floor(2^33 / den), estimate is low by at most one
   function automatic logic [30:0] sin_recip(input logic [2:0] k);
      logic [30:0] r;
      case (k)
         3'd0: r = 31'd55063683;
         3'd1: r = 31'd78090314;
         3'd2: r = 31'd119304647;
         3'd3: r = 31'd204522252;
         3'd4: r = 31'd429496729;
         3'd5: r = 31'd1431655765;
         default: r = 31'd1431655765;
      endcase
      return r;
   endfunction

   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
      logic [DIFF_W-1:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      return d[DIFF_W-1] ? (~d + 1'b1) : d;
   endfunction

   // returns {clipped, sum}
   function automatic logic [SUM_W:0] sat_add(input logic signed [SUM_W-1:0] a,
                                              input logic signed [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      logic [SUM_W:0] r;
      s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1]) begin
         r = s[SUM_W] ? {1'b1, 1'b1, {(SUM_W-1){1'b0}}} : {1'b1, 1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         r = {1'b0, s[SUM_W-1:0]};
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/psfp_sqrt_cell.sv
// one digit stage of the integer square root chain
module psfp_sqrt_cell (
   input  logic                     clock,
   input  psfp_pkg::sqrt_stage_type stage_i,
   output psfp_pkg::sqrt_stage_type stage_o
);
   import psfp_pkg::*;

   sqrt_stage_type stage_ff;
   sqrt_stage_type stage_in;
   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic             take;

   always_comb begin
      rem_sh = {stage_i.rem[REM_W-3:0], stage_i.rad[RAD_W-1 -: 2]};
      trial = {{(REM_W-ROOT_W-2){1'b0}}, stage_i.root, 2'b01};
      take = (rem_sh >= trial);
      stage_in.rad = {stage_i.rad[RAD_W-3:0], 2'b00};
      stage_in.rem = take ? (rem_sh - trial) : rem_sh;
      stage_in.root = {stage_i.root[ROOT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_o = stage_ff;

endmodule

// File: hw/rtl/psfp_term.sv
// term engine: distance, weight, phase rotation and scaling of one source
module psfp_term (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start_i,
   input  psfp_pkg::source_type      src_i,
   input  psfp_pkg::point_type       tgt_i,
   input  psfp_pkg::csr_type         csr_i,
   output logic                      done_o,
   output psfp_pkg::term_result_type result_o
);
   import psfp_pkg::*;

   term_state_type state_ff, state_in;

   source_type       src_ff, src_in;
   point_type        tgt_ff, tgt_in;
   logic [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [SQ_W-1:0]  sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [ROOT_W-1:0] r_ff, r_in;
   logic [ROOT_W-1:0] div_d_ff, div_d_in;
   logic [DIV_REM_W-1:0] div_rem_ff, div_rem_in;
   logic [QUO_W-1:0] w_ff, w_in;
   logic [1:0]       quad_ff, quad_in;
   logic [30:0]      arg_ff, arg_in, x_ff, x_in, inner_ff, inner_in;
   logic [31:0]      x2_ff, x2_in;
   logic [32:0]      v_ff, v_in;
   logic [30:0]      est_ff, est_in, s0_ff, s0_in, c0_ff, c0_in;
   logic             second_ff, second_in, zero_ff, zero_in;
   logic signed [31:0] sn_ff, sn_in, cs_ff, cs_in;
   logic signed [55:0] pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in, pd_ff, pd_in;
   logic [56:0]      vre_ff, vre_in, vim_ff, vim_in;
   logic [26:0]      mre_ff, mre_in, mim_ff, mim_in;
   logic             nre_ff, nre_in, nim_ff, nim_in;
   logic [43:0]      hre_ff, hre_in, him_ff, him_in;
   logic [58:0]      lre_ff, lre_in, lim_ff, lim_in;
   logic signed [SUM_W-1:0] re_ff, re_in, im_ff, im_in;

   sqrt_stage_type   chain [0:SQRT_STEPS];
   logic [ROOT_W-1:0] root_w;

   // radicand enters at the head, one result digit per cell
   assign chain[0] = '{rad: rad_ff, rem: '0, root: '0};

   genvar g;
   generate
      for (g = 0; g < SQRT_STEPS; g++) begin : g_cell
         psfp_sqrt_cell u_cell (
            .clock   (clock),
            .stage_i (chain[g]),
            .stage_o (chain[g+1])
         );
      end
   endgenerate

   assign root_w = chain[SQRT_STEPS].root;

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         TS_IDLE: if (start_i) state_in = TS_DIFF;
         TS_DIFF: state_in = TS_SQUARE;
         TS_SQUARE: state_in = TS_SUM;
         TS_SUM: state_in = TS_ROOT;
         TS_ROOT: begin
            if (cnt_ff == SQRT_DONE_STEP) begin
               if (root_w == '0) state_in = TS_DONE;
               else if (csr_i.geometry_mode) state_in = TS_DIV;
               else state_in = TS_ROOT_W;
            end
         end
         TS_ROOT_W: if (cnt_ff == SQRT_DONE_STEP) state_in = TS_DIV;
         TS_DIV: if (cnt_ff == '0) state_in = TS_PHASE;
         TS_PHASE: state_in = TS_SIN_X;
         TS_SIN_X: state_in = TS_SIN_X2;
         TS_SIN_X2: state_in = TS_SIN_PROD;
         TS_SIN_PROD: state_in = TS_SIN_EST;
         TS_SIN_EST: state_in = TS_SIN_FIX;
         TS_SIN_FIX: begin
            if (cnt_ff[2:0] == SIN_LAST_TERM) state_in = TS_SIN_END;
            else state_in = TS_SIN_PROD;
         end
         TS_SIN_END: state_in = second_ff ? TS_QUAD : TS_SIN_X;
         TS_QUAD: state_in = TS_MUL;
         TS_MUL: state_in = TS_COMB;
         TS_COMB: state_in = TS_MAG;
         TS_MAG: state_in = TS_SCALE;
         TS_SCALE: state_in = TS_TERM;
         TS_TERM: state_in = TS_DONE;
         TS_DONE: state_in = TS_IDLE;
         default: state_in = TS_IDLE;
      endcase
   end

   always_comb begin : outputs
      done_o = (state_ff == TS_DONE);
      result_o = '{re: re_ff, im: im_ff, zero: zero_ff};
   end

   always_comb begin : datapath
      logic [65:0] wp;
      logic [61:0] xp;
      logic [62:0] pr;
      logic [63:0] ep;
      logic [38:0] ed;
      logic [38:0] rem;
      logic [30:0] qd;
      logic [31:0] fin;
      logic [30:0] cap;
      logic        num_bit;
      logic [DIV_REM_W-1:0] rem_sh;
      logic signed [31:0] sp, cp, sn, cs;
      logic [56:0] mag_re, mag_im;
      logic [SUM_W-1:0] t_re, t_im;

      src_in = src_ff; tgt_in = tgt_ff;
      dx_in = dx_ff; dy_in = dy_ff; dz_in = dz_ff;
      sx_in = sx_ff; sy_in = sy_ff; sz_in = sz_ff;
      rad_in = rad_ff; cnt_in = cnt_ff; r_in = r_ff;
      div_d_in = div_d_ff; div_rem_in = div_rem_ff; w_in = w_ff;
      quad_in = quad_ff; arg_in = arg_ff; x_in = x_ff; x2_in = x2_ff;
      inner_in = inner_ff; v_in = v_ff; est_in = est_ff;
      s0_in = s0_ff; c0_in = c0_ff; second_in = second_ff; zero_in = zero_ff;
      sn_in = sn_ff; cs_in = cs_ff;
      pa_in = pa_ff; pb_in = pb_ff; pc_in = pc_ff; pd_in = pd_ff;
      vre_in = vre_ff; vim_in = vim_ff;
      mre_in = mre_ff; mim_in = mim_ff; nre_in = nre_ff; nim_in = nim_ff;
      hre_in = hre_ff; him_in = him_ff; lre_in = lre_ff; lim_in = lim_ff;
      re_in = re_ff; im_in = im_ff;

      wp = csr_i.wave_turns * r_ff;
      xp = '0;
      pr = x2_ff * inner_ff;
      ep = v_ff * sin_recip(cnt_ff[2:0]);
      ed = est_ff * sin_den(cnt_ff[2:0]);
      rem = {6'd0, v_ff} - ed;
      qd = est_ff + {30'd0, (rem >= {31'd0, sin_den(cnt_ff[2:0])})};
      fin = '0;
      cap = '0;
      num_bit = csr_i.geometry_mode ? (cnt_ff == SPATIAL_NUM_BIT)
                                    : (cnt_ff == PLANAR_NUM_BIT);
      rem_sh = {div_rem_ff[DIV_REM_W-2:0], num_bit};
      sp = $signed({1'b0, s0_ff});
      cp = $signed({1'b0, c0_ff});
      sn = '0;
      cs = '0;
      mag_re = vre_ff[56] ? (~vre_ff + 1'b1) : vre_ff;
      mag_im = vim_ff[56] ? (~vim_ff + 1'b1) : vim_ff;
      t_re = {4'd0, hre_ff} + {21'd0, lre_ff[58:32]};
      t_im = {4'd0, him_ff} + {21'd0, lim_ff[58:32]};

      case (state_ff)
         TS_IDLE: begin
            if (start_i) begin
               src_in = src_i;
               tgt_in = tgt_i;
               zero_in = 1'b0;
               second_in = 1'b0;
            end
         end
         TS_DIFF: begin
            dx_in = abs_diff(tgt_ff.x, src_ff.pos.x);
            dy_in = abs_diff(tgt_ff.y, src_ff.pos.y);
            dz_in = abs_diff(tgt_ff.z, src_ff.pos.z);
         end
         TS_SQUARE: begin
            sx_in = dx_ff * dx_ff;
            sy_in = dy_ff * dy_ff;
            sz_in = dz_ff * dz_ff;
         end
         TS_SUM: begin
            rad_in = {2'b00, sx_ff} + {2'b00, sy_ff}
                   + (csr_i.geometry_mode ? {2'b00, sz_ff} : '0);
            cnt_in = '0;
         end
         TS_ROOT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_DONE_STEP) begin
               r_in = root_w;
               if (root_w == '0) begin
                  zero_in = 1'b1;
               end else if (csr_i.geometry_mode) begin
                  div_d_in = root_w;
                  div_rem_in = '0;
                  cnt_in = DIV_LAST_STEP;
               end else begin
                  // second root gives sqrt(r) for the planar weight
                  rad_in = {{(RAD_W-ROOT_W){1'b0}}, root_w} << PLANAR_SHIFT;
                  cnt_in = '0;
               end
            end
         end
         TS_ROOT_W: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_DONE_STEP) begin
               div_d_in = root_w;
               div_rem_in = '0;
               cnt_in = DIV_LAST_STEP;
            end
         end
         TS_DIV: begin
            // restoring division of a power of two, one quotient bit per cycle
            if (rem_sh >= {1'b0, div_d_ff}) begin
               div_rem_in = rem_sh - {1'b0, div_d_ff};
               w_in = {w_ff[QUO_W-2:0], 1'b1};
            end else begin
               div_rem_in = rem_sh;
               w_in = {w_ff[QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end
         TS_PHASE: begin
            quad_in = wp[39:38];
            arg_in = {1'b0, wp[37:8]};
         end
         TS_SIN_X: begin
            xp = arg_ff * HALF_PI_Q30;
            x_in = xp[60:30];
         end
         TS_SIN_X2: begin
            xp = x_ff * x_ff;
            x2_in = xp[61:30];
            inner_in = ONE_Q30;
            cnt_in = '0;
         end
         TS_SIN_PROD: v_in = pr[62:30];
         TS_SIN_EST: est_in = ep[63:33];
         TS_SIN_FIX: begin
            inner_in = ONE_Q30 - qd;
            cnt_in = cnt_ff + 1'b1;
         end
         TS_SIN_END: begin
            xp = x_ff * inner_ff;
            fin = xp[61:30];
            cap = (fin > {1'b0, ONE_Q30}) ? ONE_Q30 : fin[30:0];
            if (!second_ff) begin
               s0_in = cap;
               second_in = 1'b1;
               arg_in = ONE_Q30 - arg_ff;
            end else begin
               c0_in = cap;
            end
         end
         TS_QUAD: begin
            case (quad_ff)
               2'd0: begin sn = sp; cs = cp; end
               2'd1: begin sn = cp; cs = -sp; end
               2'd2: begin sn = -sp; cs = -cp; end
               default: begin sn = -cp; cs = sp; end
            endcase
            sn_in = csr_i.direction ? -sn : sn;
            cs_in = cs;
         end
         TS_MUL: begin
            pa_in = src_ff.re * cs_ff;
            pb_in = src_ff.im * sn_ff;
            pc_in = src_ff.re * sn_ff;
            pd_in = src_ff.im * cs_ff;
         end
         TS_COMB: begin
            vre_in = {pa_ff[55], pa_ff} - {pb_ff[55], pb_ff};
            vim_in = {pc_ff[55], pc_ff} + {pd_ff[55], pd_ff};
         end
         TS_MAG: begin
            nre_in = vre_ff[56];
            nim_in = vim_ff[56];
            mre_in = mag_re[56:30];
            mim_in = mag_im[56:30];
         end
         TS_SCALE: begin
            hre_in = mre_ff * w_ff[48:32];
            lre_in = mre_ff * w_ff[31:0];
            him_in = mim_ff * w_ff[48:32];
            lim_in = mim_ff * w_ff[31:0];
         end
         TS_TERM: begin
            re_in = nre_ff ? -$signed(t_re) : $signed(t_re);
            im_in = nim_ff ? -$signed(t_im) : $signed(t_im);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TS_IDLE;
         cnt_ff <= '0;
         second_ff <= 1'b0;
         zero_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         second_ff <= second_in;
         zero_ff <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in; tgt_ff <= tgt_in;
      dx_ff <= dx_in; dy_ff <= dy_in; dz_ff <= dz_in;
      sx_ff <= sx_in; sy_ff <= sy_in; sz_ff <= sz_in;
      rad_ff <= rad_in; r_ff <= r_in;
      div_d_ff <= div_d_in; div_rem_ff <= div_rem_in; w_ff <= w_in;
      quad_ff <= quad_in; arg_ff <= arg_in; x_ff <= x_in; x2_ff <= x2_in;
      inner_ff <= inner_in; v_ff <= v_in; est_ff <= est_in;
      s0_ff <= s0_in; c0_ff <= c0_in;
      sn_ff <= sn_in; cs_ff <= cs_in;
      pa_ff <= pa_in; pb_ff <= pb_in; pc_ff <= pc_in; pd_ff <= pd_in;
      vre_ff <= vre_in; vim_ff <= vim_in;
      mre_ff <= mre_in; mim_ff <= mim_in; nre_ff <= nre_in; nim_ff <= nim_in;
      hre_ff <= hre_in; him_ff <= him_in; lre_ff <= lre_in; lim_ff <= lim_in;
      re_ff <= re_in; im_ff <= im_in;
   end

endmodule

// File: hw/rtl/point_source_field_propagator.sv
// top level: source memory, command control, accumulation and result register
// store and clear act as the request is taken; evaluate visits every stored source in turn
// each source passes the 34-cell root chain and, unless at zero distance, the 53-step divider
// synchronous reset clears the source count, the CSRs, the response valid and the control state
module point_source_field_propagator #(
   parameter int MAX_SOURCES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic signed [23:0] req_field_re,
   input  logic signed [23:0] req_field_im,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [47:0] rsp_sum_re,
   output logic signed [47:0] rsp_sum_im,
   output logic        rsp_saturated,
   output logic        rsp_zero_distance,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import psfp_pkg::*;

   localparam int ADDR_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int CNT_W = $clog2(MAX_SOURCES + 1);

   top_state_type state_ff, state_in;
   csr_type       csr_ff, csr_in;
   logic [CNT_W-1:0] count_ff, count_in, idx_ff, idx_in, idx_next;
   point_type     target_ff, target_in;
   logic signed [SUM_W-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic          sat_ff, sat_in, zero_ff, zero_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic          rsp_sat_ff, rsp_sat_in, rsp_zero_ff, rsp_zero_in;

   source_type    mem_q [0:MAX_SOURCES-1];
   source_type    rd_ff;
   source_type    wr_data;

   logic          req_fire, store_en, has_room, rsp_free;
   logic          term_start, term_done;
   term_result_type term_res;
   logic [SUM_W:0] add_re, add_im;

   assign req_fire = req_valid && req_ready;
   assign has_room = (count_ff < CNT_W'(MAX_SOURCES));
   assign store_en = req_fire && (req_cmd == CMD_STORE) && has_room;
   assign idx_next = idx_ff + CNT_W'(1);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign wr_data = '{pos: '{x: req_coord_x, y: req_coord_y, z: req_coord_z},
                      re: req_field_re, im: req_field_im};

   always_ff @(posedge clock) begin
      if (store_en) begin
         mem_q[count_ff[ADDR_W-1:0]] <= wr_data;
      end
      rd_ff <= mem_q[idx_ff[ADDR_W-1:0]];
   end

   psfp_term u_term (
      .clock    (clock),
      .reset    (reset),
      .start_i  (term_start),
      .src_i    (rd_ff),
      .tgt_i    (target_ff),
      .csr_i    (csr_ff),
      .done_o   (term_done),
      .result_o (term_res)
   );

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         TOP_IDLE: begin
            if (req_valid && (req_cmd == CMD_EVAL)) begin
               state_in = (count_ff == '0) ? TOP_RESULT : TOP_READ;
            end
         end
         TOP_READ: state_in = TOP_START;
         TOP_START: state_in = TOP_WAIT;
         TOP_WAIT: begin
            if (term_done) begin
               state_in = (idx_next == count_ff) ? TOP_RESULT : TOP_READ;
            end
         end
         TOP_RESULT: if (rsp_free) state_in = TOP_IDLE;
         default: state_in = TOP_IDLE;
      endcase
   end

   always_comb begin : outputs
      req_ready = (state_ff == TOP_IDLE);
      term_start = (state_ff == TOP_START);
      rsp_valid = rsp_valid_ff;
      rsp_sum_re = rsp_re_ff;
      rsp_sum_im = rsp_im_ff;
      rsp_saturated = rsp_sat_ff;
      rsp_zero_distance = rsp_zero_ff;
   end

   always_comb begin : datapath
      csr_in = csr_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      target_in = target_ff;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      sat_in = sat_ff;
      zero_in = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_re_in = rsp_re_ff;
      rsp_im_in = rsp_im_ff;
      rsp_sat_in = rsp_sat_ff;
      rsp_zero_in = rsp_zero_ff;
      add_re = sat_add(acc_re_ff, term_res.re);
      add_im = sat_add(acc_im_ff, term_res.im);

      if (csr_wen) begin
         case (csr_index)
            CSR_WAVE_TURNS: csr_in.wave_turns = csr_wdata;
            CSR_DIRECTION: csr_in.direction = csr_wdata[0];
            CSR_GEOMETRY: csr_in.geometry_mode = csr_wdata[0];
            default: ;
         endcase
      end

      if (req_fire) begin
         case (req_cmd)
            CMD_STORE: if (has_room) count_in = count_ff + CNT_W'(1);
            CMD_CLEAR: count_in = '0;
            CMD_EVAL: begin
               target_in = '{x: req_coord_x, y: req_coord_y, z: req_coord_z};
               idx_in = '0;
               acc_re_in = '0;
               acc_im_in = '0;
               sat_in = 1'b0;
               zero_in = 1'b0;
            end
            default: ;
         endcase
      end

      if ((state_ff == TOP_WAIT) && term_done) begin
         idx_in = idx_next;
         if (term_res.zero) begin
            zero_in = 1'b1;
         end else begin
            acc_re_in = add_re[SUM_W-1:0];
            acc_im_in = add_im[SUM_W-1:0];
            sat_in = sat_ff || add_re[SUM_W] || add_im[SUM_W];
         end
      end

      if ((state_ff == TOP_RESULT) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_re_in = acc_re_ff;
         rsp_im_in = acc_im_ff;
         rsp_sat_in = sat_ff;
         rsp_zero_in = zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TOP_IDLE;
         csr_ff <= '0;
         count_ff <= '0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         csr_ff <= csr_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      sat_ff <= sat_in;
      zero_ff <= zero_in;
      rsp_re_ff <= rsp_re_in;
      rsp_im_ff <= rsp_im_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_zero_ff <= rsp_zero_in;
   end

endmodule

// File: hw/rtl/psfp_checker.sv
// port-level checker for the point source field propagator, with its bind
`include "assert_macros.svh"

module psfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_cmd,
   input logic signed [31:0] req_coord_x,
   input logic signed [31:0] req_coord_y,
   input logic signed [31:0] req_coord_z,
   input logic signed [23:0] req_field_re,
   input logic signed [23:0] req_field_im,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic signed [47:0] rsp_sum_re,
   input logic signed [47:0] rsp_sum_im,
   input logic        rsp_saturated,
   input logic        rsp_zero_distance,
   input logic        csr_wen,
   input logic [1:0]  csr_index,
   input logic [31:0] csr_wdata
);
   import psfp_pkg::*;

   logic eval_beat;
   logic other_beat;
   logic rsp_stall;

   assign eval_beat = req_valid && req_ready && (req_cmd == CMD_EVAL);
   assign other_beat = req_valid && req_ready && (req_cmd != CMD_EVAL);
   assign rsp_stall = rsp_valid && !rsp_ready;

   // a stalled result beat keeps its flags
   `PSFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_saturated) && $stable(rsp_zero_distance))
   // an evaluate beat makes the block busy until its result is queued
   `PSFP_ASSERT_NEXT(a_eval_busy, clock, reset, eval_beat, !req_ready)
   // store, clear and unused commands never produce a result beat
   `PSFP_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, other_beat, !$rose(rsp_valid))
   // a rising result beat follows a spell in which the block was not ready
   `PSFP_ASSERT_SAME(a_rsp_while_busy, clock, reset, $rose(rsp_valid), !$past(req_ready))

endmodule

bind point_source_field_propagator psfp_checker u_psfp_checker (.*);
